// File: hw/rtl/tksb_pkg.sv
// Shared item types and operation codes for the top-k score board.
`default_nettype none

package tksb_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_READ   = 1'b1;

   typedef struct packed {
      logic               operation;
      logic signed [31:0] new_score;
      logic [15:0]        new_tag;
      logic [4:0]         read_rank;
   } req_type;

   typedef struct packed {
      logic               accepted;
      logic signed [31:0] rank_score;
      logic [15:0]        rank_tag;
   } rsp_type;

endpackage

`default_nettype wire

// File: hw/rtl/tksb_board.sv
// Sorted entry storage with a parallel insert and a rank read.
`default_nettype none

module tksb_board #(
   parameter int BOARD_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_valid,
   input  tksb_pkg::req_type item,
   output tksb_pkg::rsp_type result
);
   import tksb_pkg::*;

   localparam int IDX_W  = $clog2(BOARD_DEPTH);
   localparam int RANK_W = $bits(item.read_rank);
   localparam int CMP_W  = ((IDX_W > RANK_W) ? IDX_W : RANK_W) + 1;

   logic signed [31:0] score_ff [BOARD_DEPTH];
   logic signed [31:0] score_in [BOARD_DEPTH];
   logic [15:0]        tag_ff   [BOARD_DEPTH];
   logic [15:0]        tag_in   [BOARD_DEPTH];
   logic [BOARD_DEPTH-1:0] less;
   logic               do_insert;
   logic [CMP_W-1:0]   rank_ext;
   logic [IDX_W-1:0]   rank_idx;
   logic               rank_in_range;

   // The board is kept in descending order, so the set of entries below the
   // candidate is a contiguous run at the bottom.
   always_comb begin
      for (int i = 0; i < BOARD_DEPTH; i++) begin
         less[i] = $signed(score_ff[i]) < $signed(item.new_score);
      end
   end

   assign do_insert = item_valid && (item.operation == OP_INSERT) && less[BOARD_DEPTH-1];

   always_comb begin
      score_in[0] = score_ff[0];
      tag_in[0]   = tag_ff[0];
      if (less[0]) begin
         score_in[0] = item.new_score;
         tag_in[0]   = item.new_tag;
      end
      for (int i = 1; i < BOARD_DEPTH; i++) begin
         score_in[i] = score_ff[i];
         tag_in[i]   = tag_ff[i];
         if (less[i]) begin
            if (less[i-1]) begin
               score_in[i] = score_ff[i-1];
               tag_in[i]   = tag_ff[i-1];
            end else begin
               score_in[i] = item.new_score;
               tag_in[i]   = item.new_tag;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BOARD_DEPTH; i++) begin
            score_ff[i] <= '0;
            tag_ff[i]   <= '0;
         end
      end else if (do_insert) begin
         for (int i = 0; i < BOARD_DEPTH; i++) begin
            score_ff[i] <= score_in[i];
            tag_ff[i]   <= tag_in[i];
         end
      end
   end

   assign rank_ext      = CMP_W'(item.read_rank);
   assign rank_idx      = rank_ext[IDX_W-1:0];
   assign rank_in_range = rank_ext < CMP_W'(BOARD_DEPTH);

   always_comb begin
      result.accepted   = do_insert;
      result.rank_score = '0;
      result.rank_tag   = '0;
      if ((item.operation == OP_READ) && rank_in_range) begin
         result.rank_score = score_ff[rank_idx];
         result.rank_tag   = tag_ff[rank_idx];
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/top_k_score_board_unit.sv
// Top level of the top-k score board: request and result registers around the board.
// Keeps the BOARD_DEPTH highest (score, tag) pairs in descending score order.
// Request channel: an item is taken at a clock edge where start is high and
// busy is low. Busy is only raised while reset is asserted, so one item can
// be taken on every clock cycle.
// An insert item enters when its signed score beats the lowest entry; it
// lands below any older entries with an equal score and the lowest entry
// drops off. A read item returns the entry at read_rank, or zeros when the
// rank lies past the board.
// Result channel: every item yields exactly one result, shown for one cycle
// with rsp_valid high, once the item has passed the request and result registers. The receiver has
// no way to hold results off, so none are ever queued.
// Throughput is one item per cycle: all entries compare against the new
// score at once and shift by one place together, so an item sees
// every update made by the item before it.
// Reset (synchronous) clears every entry to score 0, tag 0 and drops any
// item in flight.
`default_nettype none

module top_k_score_board_unit #(
   parameter int BOARD_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tksb_pkg::req_type req_item,
   output logic              rsp_valid,
   output tksb_pkg::rsp_type rsp_item
);
   import tksb_pkg::*;

   logic    req_valid_ff;
   logic    req_valid_in;
   req_type req_ff;
   rsp_type result_in;
   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   assign busy         = reset;
   assign req_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_item;
      end
      if (req_valid_ff) begin
         rsp_ff <= result_in;
      end
   end

   tksb_board #(
      .BOARD_DEPTH(BOARD_DEPTH)
   ) u_board (
      .clock      (clock),
      .reset      (reset),
      .item_valid (req_valid_ff),
      .item       (req_ff),
      .result     (result_in)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef SYNTHESIS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted item did not produce a result two cycles later");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_valid_ff))
      else $error("result strobe without an item in the request register");

   a_insert_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.accepted) |->
         (rsp_item.rank_score == '0 && rsp_item.rank_tag == '0))
      else $error("accepted insert carries nonzero rank fields");
`endif

endmodule

`default_nettype wire

// File: tb/sv/tb_top.sv
// Self-checking testbench for the top-k score board: directed table, then random bursts.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import tksb_pkg::*;

   localparam int          DEPTH        = 32;
   localparam int          RANDOM_ITEMS = 1800;
   localparam int          CYCLE_LIMIT  = 200000;
   localparam logic [31:0] SCORE_MAX    = 32'h7FFF_FFFF;
   localparam logic [31:0] SCORE_MIN    = 32'h8000_0000;

   typedef struct packed {
      req_type item;
      logic    typed;
      rsp_type rsp;
   } directed_row_type;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   // Predicted board contents, kept in descending score order.
   logic signed [31:0] board_score [DEPTH];
   logic [15:0]        board_tag [DEPTH];

   rsp_type expected_rsp_q [$];
   int      mismatch_count = 0;
   int      cycle_count = 0;

   // Rows with typed = 1 carry a result that is obvious from the board contents;
   // the rest are checked against the board predictor.
   directed_row_type directed_rows [18] = '{
      '{'{OP_READ,   32'sd0,    16'h0000, 5'd0},  1'b1, '{1'b0, 32'sd0,    16'h0000}},
      '{'{OP_READ,   SCORE_MIN, 16'hFFFF, 5'd31}, 1'b1, '{1'b0, 32'sd0,    16'h0000}},
      '{'{OP_INSERT, 32'sd0,    16'hFFFF, 5'd31}, 1'b1, '{1'b0, 32'sd0,    16'h0000}},
      '{'{OP_INSERT, -32'sd1,   16'h1234, 5'd0},  1'b1, '{1'b0, 32'sd0,    16'h0000}},
      '{'{OP_INSERT, SCORE_MIN, 16'h0001, 5'd0},  1'b1, '{1'b0, 32'sd0,    16'h0000}},
      '{'{OP_INSERT, SCORE_MAX, 16'hFFFF, 5'd31}, 1'b1, '{1'b1, 32'sd0,    16'h0000}},
      '{'{OP_READ,   32'sd0,    16'h0000, 5'd0},  1'b1, '{1'b0, SCORE_MAX, 16'hFFFF}},
      '{'{OP_INSERT, 32'sd1,    16'h0001, 5'd0},  1'b1, '{1'b1, 32'sd0,    16'h0000}},
      '{'{OP_INSERT, 32'sd1,    16'h0002, 5'd0},  1'b1, '{1'b1, 32'sd0,    16'h0000}},
      '{'{OP_READ,   32'sd0,    16'h0000, 5'd1},  1'b1, '{1'b0, 32'sd1,    16'h0001}},
      '{'{OP_READ,   32'sd0,    16'h0000, 5'd2},  1'b1, '{1'b0, 32'sd1,    16'h0002}},
      '{'{OP_INSERT, SCORE_MAX, 16'h0003, 5'd0},  1'b1, '{1'b1, 32'sd0,    16'h0000}},
      '{'{OP_READ,   32'sd0,    16'h0000, 5'd0},  1'b1, '{1'b0, SCORE_MAX, 16'hFFFF}},
      '{'{OP_READ,   32'sd0,    16'h0000, 5'd1},  1'b1, '{1'b0, SCORE_MAX, 16'h0003}},
      '{'{OP_READ,   32'sd0,    16'h0000, 5'd31}, 1'b1, '{1'b0, 32'sd0,    16'h0000}},
      '{'{OP_INSERT, 32'sd1,    16'h0004, 5'd17}, 1'b1, '{1'b1, 32'sd0,    16'h0000}},
      '{'{OP_READ,   32'sd0,    16'h0000, 5'd3},  1'b1, '{1'b0, 32'sd1,    16'h0002}},
      '{'{OP_READ,   SCORE_MAX, 16'hA5A5, 5'd4},  1'b0, '{1'b0, 32'sd0,    16'h0000}}
   };

   top_k_score_board_unit #(.BOARD_DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Applies one item to the predicted board and returns the result it should give.
   function automatic rsp_type board_predict(req_type item);
      rsp_type res;
      int      pos;
      res = '0;
      if (item.operation == OP_INSERT) begin
         if ($signed(item.new_score) > board_score[DEPTH-1]) begin
            pos = DEPTH - 1;
            // Strictly smaller scores move down; equal scores keep their place above.
            while (pos > 0 && board_score[pos-1] < $signed(item.new_score)) begin
               board_score[pos] = board_score[pos-1];
               board_tag[pos]   = board_tag[pos-1];
               pos--;
            end
            board_score[pos] = item.new_score;
            board_tag[pos]   = item.new_tag;
            res.accepted     = 1'b1;
         end
      end else if (item.read_rank < DEPTH) begin
         res.rank_score = board_score[item.read_rank];
         res.rank_tag   = board_tag[item.read_rank];
      end
      return res;
   endfunction

   // Scores are mostly drawn near the current board contents so that inserts
   // keep landing at every rank, including ties with existing entries.
   function automatic req_type random_item();
      req_type item;
      int      pick;
      item.operation = ($urandom_range(0, 1) == 0) ? OP_INSERT : OP_READ;
      item.new_tag   = 16'($urandom_range(0, 16'hFFFF));
      item.read_rank = 5'($urandom_range(0, DEPTH - 1));
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         item.new_score = board_score[$urandom_range(0, DEPTH - 1)];
      end else if (pick < 60) begin
         item.new_score = board_score[$urandom_range(0, DEPTH - 1)] + $urandom_range(1, 1000);
      end else if (pick < 85) begin
         item.new_score = $urandom;
      end else if (pick < 95) begin
         item.new_score = board_score[DEPTH-1] - $urandom_range(0, 3);
      end else begin
         case ($urandom_range(0, 3))
            0: item.new_score = SCORE_MIN;
            1: item.new_score = SCORE_MAX;
            2: item.new_score = 32'sd0;
            default: item.new_score = -32'sd1;
         endcase
      end
      return item;
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic drive_item(input req_type item, input logic typed, input rsp_type typed_rsp);
      rsp_type predicted;
      req_item <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      predicted = board_predict(item);
      @(negedge clock);
      expected_rsp_q.insert(expected_rsp_q.size(), typed ? typed_rsp : predicted);
   endtask

   task automatic idle_gap(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      do @(negedge clock); while (expected_rsp_q.size() != 0);
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
      if (!reset && rsp_valid) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, rsp_item);
            mismatch_count++;
         end else begin
            exp_rsp = expected_rsp_q.pop_front();
            if (rsp_item.accepted !== exp_rsp.accepted) begin
               $display("%0t: accepted expected %0b actual %0b",
                        $time, exp_rsp.accepted, rsp_item.accepted);
               mismatch_count++;
            end
            if (rsp_item.rank_score !== exp_rsp.rank_score) begin
               $display("%0t: rank_score expected %0d actual %0d",
                        $time, exp_rsp.rank_score, rsp_item.rank_score);
               mismatch_count++;
            end
            if (rsp_item.rank_tag !== exp_rsp.rank_tag) begin
               $display("%0t: rank_tag expected 0x%04h actual 0x%04h",
                        $time, exp_rsp.rank_tag, rsp_item.rank_tag);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int sent;
      int burst_len;
      int gap;
      bit drained_midway;
      reset    = 1'b1;
      start    = 1'b0;
      req_item = '0;
      for (int i = 0; i < DEPTH; i++) begin
         board_score[i] = '0;
         board_tag[i]   = '0;
      end
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // With the default depth every 5-bit rank lies on the board, so the
      // past-the-end read case cannot be reached here.
      foreach (directed_rows[i]) begin
         drive_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].rsp);
      end
      wait_for_results();

      sent = 0;
      drained_midway = 1'b0;
      while (sent < RANDOM_ITEMS) begin
         burst_len = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         for (int i = 0; i < burst_len && sent < RANDOM_ITEMS; i++) begin
            drive_item(random_item(), 1'b0, '0);
            sent++;
         end
         if (!drained_midway && sent >= RANDOM_ITEMS / 2) begin
            drained_midway = 1'b1;
            wait_for_results();
         end else if (gap != 0) begin
            idle_gap(gap);
         end
      end

      wait_for_results();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
